/* hw/rtl/stbs_pkg.sv */
package stbs_pkg;

  localparam int unsigned ValueW    = 16;
  localparam int unsigned CountW    = 9;
  localparam int unsigned IndexW    = 8;
  localparam int unsigned PositionW = 8;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    OC_LOW   = 2'd0,
    OC_HIGH  = 2'd1,
    OC_MATCH = 2'd2,
    OC_MISS  = 2'd3
  } stbs_outcome_t;

  typedef struct packed {
    logic                      start;
    logic signed [ValueW-1:0]  target;
  } stbs_req_t;

  typedef struct packed {
    logic                  valid;
    logic [PositionW-1:0]  position;
    stbs_outcome_t         outcome;
  } stbs_res_t;

endpackage

/* hw/rtl/stbs_ram.sv */
module stbs_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/stbs_engine.sv */
module stbs_engine
  import stbs_pkg::*;
#(
  parameter int unsigned AW = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  stbs_req_t                req,
  input  logic [AW-1:0]            last_idx,
  output logic                     rd_en,
  output logic [AW-1:0]            rd_addr,
  input  logic signed [ValueW-1:0] rd_data,
  output logic                     idle,
  input  logic                     out_ready,
  output stbs_res_t                res
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FIRST = 4'b0010,
    S_LAST  = 4'b0100,
    S_PROBE = 4'b1000
  } state_t;

  state_t                    state_r, state_nxt;
  logic signed [ValueW-1:0]  target_r, target_nxt;
  logic [AW-1:0]             lo_r, lo_nxt;
  logic [AW-1:0]             hi_r, hi_nxt;
  logic [AW-1:0]             mid_r, mid_nxt;
  logic                      res_valid_r, res_valid_nxt;
  logic [PositionW-1:0]      res_pos_r, res_pos_nxt;
  stbs_outcome_t             res_oc_r, res_oc_nxt;

  logic                      blocked;
  logic                      fin;
  logic [PositionW-1:0]      fin_pos;
  stbs_outcome_t             fin_oc;
  logic [AW:0]               sum_dn;
  logic [AW:0]               sum_up;
  logic [AW-1:0]             mid_dn;
  logic [AW-1:0]             mid_up;
  logic [AW-1:0]             mid_first;

  assign sum_dn    = {1'b0, lo_r} + {1'b0, mid_r} - {{AW{1'b0}}, 1'b1};
  assign sum_up    = {1'b0, mid_r} + {1'b0, hi_r} + {{AW{1'b0}}, 1'b1};
  assign mid_dn    = sum_dn[AW:1];
  assign mid_up    = sum_up[AW:1];
  assign mid_first = last_idx >> 1;
  assign blocked   = res_valid_r && !out_ready;

  always_comb begin
    state_nxt     = state_r;
    target_nxt    = target_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_valid_nxt = res_valid_r && !out_ready;
    res_pos_nxt   = res_pos_r;
    res_oc_nxt    = res_oc_r;
    rd_en         = 1'b0;
    rd_addr       = '0;
    fin           = 1'b0;
    fin_pos       = '0;
    fin_oc        = OC_MISS;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          target_nxt = req.target;
          rd_en      = 1'b1;
          rd_addr    = '0;
          state_nxt  = S_FIRST;
        end
      end
      S_FIRST: begin
        if (target_r <= rd_data) begin
          fin    = 1'b1;
          fin_oc = OC_LOW;
        end else begin
          rd_en     = 1'b1;
          rd_addr   = last_idx;
          state_nxt = S_LAST;
        end
      end
      S_LAST: begin
        if (target_r >= rd_data) begin
          fin     = 1'b1;
          fin_pos = PositionW'(last_idx);
          fin_oc  = OC_HIGH;
        end else begin
          lo_nxt    = '0;
          hi_nxt    = last_idx;
          mid_nxt   = mid_first;
          rd_en     = 1'b1;
          rd_addr   = mid_first;
          state_nxt = S_PROBE;
        end
      end
      S_PROBE: begin
        priority if (rd_data == target_r) begin
          fin     = 1'b1;
          fin_pos = PositionW'(mid_r);
          fin_oc  = OC_MATCH;
        end else if (rd_data > target_r) begin
          if (mid_r == lo_r) begin
            fin = 1'b1;
          end else begin
            hi_nxt  = mid_r - {{(AW-1){1'b0}}, 1'b1};
            mid_nxt = mid_dn;
            rd_en   = 1'b1;
            rd_addr = mid_dn;
          end
        end else begin
          if (mid_r == hi_r) begin
            fin = 1'b1;
          end else begin
            lo_nxt  = mid_r + {{(AW-1){1'b0}}, 1'b1};
            mid_nxt = mid_up;
            rd_en   = 1'b1;
            rd_addr = mid_up;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // hold the finished search until the output register frees
    if (fin && !blocked) begin
      res_valid_nxt = 1'b1;
      res_pos_nxt   = fin_pos;
      res_oc_nxt    = fin_oc;
      state_nxt     = S_IDLE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      res_valid_r <= res_valid_nxt;
    end
    target_r  <= target_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    res_pos_r <= res_pos_nxt;
    res_oc_r  <= res_oc_nxt;
  end

  assign idle         = (state_r == S_IDLE);
  assign res.valid    = res_valid_r;
  assign res.position = res_pos_r;
  assign res.outcome  = res_oc_r;

  a_probe_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (lo_r <= mid_r) && (mid_r <= hi_r))
    else $error("probe index outside search window");

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROBE) |-> (hi_r <= last_idx))
    else $error("search window beyond last counted entry");

  a_start_reads_first: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && req.start) |=> (state_r == S_FIRST))
    else $error("search start did not read the first entry");

  a_result_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(res_valid_r) |-> $past(state_r != S_IDLE))
    else $error("result raised without a running search");

endmodule

/* hw/rtl/sorted_table_binary_search_core.sv */
// Channel  Direction  Handshake              Transaction
// in_      input      in_valid / in_ready    cmd, entry_index, value (write or search)
// out_     output     out_valid / out_ready  position, outcome (one per search)
// cfg_     input      cfg_valid / cfg_ready  entry_count
//
// Write: the entry is written as the item is accepted. Search: reads the first
// entry and ends if the target is at or below it, else reads the last and ends
// if at or above it, otherwise probes, at most floor(log2(count)) + 1 probes.
// One table read per search step goes through the single RAM read port.
// Reset clears control and sets the count to 1; table entries stay undefined
// until written, no clearing pass.
// A result waits in the output register; writes are still taken, and a search
// that finishes while it is full holds until it drains.
module sorted_table_binary_search_core
  import stbs_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_cmd,
  input  logic [IndexW-1:0]        in_entry_index,
  input  logic signed [ValueW-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [PositionW-1:0]     out_position,
  output logic [1:0]               out_outcome,
  input  logic                     cfg_valid,
  output logic                     cfg_ready,
  input  logic [CountW-1:0]        cfg_data
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned MW = (CW > CountW) ? CW : CountW;

  logic [AW-1:0]            last_idx_r, last_idx_nxt;
  logic                     in_acc;
  logic                     ram_we;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [ValueW-1:0]        rd_raw;
  logic signed [ValueW-1:0] rd_data;
  logic                     idle;
  stbs_req_t                req;
  stbs_res_t                res;
  logic [MW-1:0]            cnt_ext;

  assign cnt_ext = MW'(cfg_data);

  always_comb begin
    last_idx_nxt = last_idx_r;
    if (cfg_valid && cfg_ready) begin
      priority if (cnt_ext == '0) begin
        last_idx_nxt = '0;
      end else if (cnt_ext > MW'(TABLE_DEPTH)) begin
        last_idx_nxt = AW'(TABLE_DEPTH - 1);
      end else begin
        last_idx_nxt = AW'(cnt_ext - MW'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_idx_r <= '0;
    end else begin
      last_idx_r <= last_idx_nxt;
    end
  end

  assign cfg_ready  = 1'b1;
  assign in_ready   = idle;
  assign in_acc     = in_valid && in_ready;
  // drop writes beyond the table
  assign ram_we     = in_acc && (in_cmd == CMD_WRITE)
                      && ({24'd0, in_entry_index} < 32'(TABLE_DEPTH));
  assign req.start  = in_acc && (in_cmd == CMD_SEARCH);
  assign req.target = in_value;
  assign rd_data    = rd_raw;

  stbs_ram #(
    .WIDTH (ValueW),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(in_entry_index)),
    .wdata (in_value),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (rd_raw)
  );

  stbs_engine #(
    .AW (AW)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .last_idx  (last_idx_r),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .idle      (idle),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_valid    = res.valid;
  assign out_position = res.position;
  assign out_outcome  = res.outcome;

endmodule

/* dv/sorted_table_binary_search_core_test.sv */
`timescale 1ns / 100ps

module sorted_table_binary_search_core_test;
  import stbs_pkg::*;

  localparam int TableDepth    = 256;
  localparam int ItemTarget    = 420;
  localparam int DrainCycles   = 32;
  localparam int HoldOffCycles = 400;
  localparam int CycleLimit    = 200000;

  typedef struct packed {
    logic [PositionW-1:0] position;
    stbs_outcome_t        outcome;
  } search_result_t;

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t        kind;
    logic             cmd;
    logic [IndexW-1:0] idx;
    logic [ValueW-1:0] value;
    logic [CountW-1:0] count;
    logic             typed;
    search_result_t   answer;
  } stim_row_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_ready;
  logic                     in_cmd;
  logic [IndexW-1:0]        in_entry_index;
  logic signed [ValueW-1:0] in_value;
  logic                     out_valid;
  logic                     out_ready;
  logic [PositionW-1:0]     out_position;
  logic [1:0]               out_outcome;
  logic                     cfg_valid;
  logic                     cfg_ready;
  logic [CountW-1:0]        cfg_data;

  logic signed [ValueW-1:0] entry_model [TableDepth];
  logic [CountW-1:0]        entry_count_model;
  search_result_t           expected_results [$];
  stim_row_t                directed_rows [$];
  int                       items_sent;
  int                       burst_left;
  int                       mismatches;
  int                       cycles;

  sorted_table_binary_search_core #(
    .TABLE_DEPTH(TableDepth)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_entry_index (in_entry_index),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_position   (out_position),
    .out_outcome    (out_outcome),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int counted_entries();
    int span;
    span = int'(entry_count_model);
    if (span == 0) span = 1;
    if (span > TableDepth) span = TableDepth;
    return span;
  endfunction

  function automatic search_result_t search_answer(input logic signed [ValueW-1:0] target);
    search_result_t res;
    int span;
    int lo;
    int hi;
    int mid;
    span = counted_entries();
    res.position = '0;
    res.outcome = OC_MISS;
    if (target <= entry_model[0]) begin
      res.outcome = OC_LOW;
      return res;
    end
    if (target >= entry_model[span-1]) begin
      res.position = PositionW'(span - 1);
      res.outcome = OC_HIGH;
      return res;
    end
    lo = 0;
    hi = span - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      if (entry_model[mid] > target) begin
        hi = mid - 1;
      end else if (entry_model[mid] < target) begin
        lo = mid + 1;
      end else begin
        res.position = PositionW'(mid);
        res.outcome = OC_MATCH;
        return res;
      end
    end
    return res;
  endfunction

  function automatic stim_row_t write_row(input int idx, input int value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd = CMD_WRITE;
    row.idx = IndexW'(idx);
    row.value = ValueW'(value);
    return row;
  endfunction

  function automatic stim_row_t search_row(input int value);
    stim_row_t row;
    row = '0;
    row.kind = ROW_ITEM;
    row.cmd = CMD_SEARCH;
    row.value = ValueW'(value);
    return row;
  endfunction

  function automatic stim_row_t known_row(input int value, input int pos, input stbs_outcome_t oc);
    stim_row_t row;
    row = search_row(value);
    row.typed = 1'b1;
    row.answer.position = PositionW'(pos);
    row.answer.outcome = oc;
    return row;
  endfunction

  function automatic stim_row_t count_row(input int cnt);
    stim_row_t row;
    row = '0;
    row.kind = ROW_CFG;
    row.count = CountW'(cnt);
    return row;
  endfunction

  task automatic offer(input logic cmd, input logic [IndexW-1:0] idx,
                       input logic [ValueW-1:0] value, input logic typed,
                       input search_result_t answer);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_entry_index <= idx;
    in_value <= value;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (cmd == CMD_WRITE) begin
      entry_model[idx] = value;
    end else if (typed) begin
      expected_results.push_back(answer);
    end else begin
      expected_results.push_back(search_answer(value));
    end
  endtask

  // drain everything first, the count may only change while idle
  task automatic set_entry_count(input logic [CountW-1:0] cnt);
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= cnt;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    entry_count_model = cnt;
    burst_left = 0;
  endtask

  initial begin
    search_result_t want;
    int stall_left;
    int hold_left;
    int results_seen;
    int held_at;
    logic ready_now;
    stall_left = 0;
    hold_left = 0;
    results_seen = 0;
    held_at = -1;
    ready_now = 1'b1;
    mismatches = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: position %0d outcome %0d", out_position, out_outcome);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (out_position !== want.position) begin
            $error("position: expected %0d, got %0d", want.position, out_position);
            mismatches++;
          end
          if (out_outcome !== want.outcome) begin
            $error("outcome: expected %0d, got %0d", want.outcome, out_outcome);
            mismatches++;
          end
        end
        results_seen++;
      end
      if (!rst_n) begin
        out_ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if ((results_seen == 25 || results_seen == 90) && held_at != results_seen) begin
        // hold off long enough to back the search pipe up into the input
        held_at = results_seen;
        hold_left = HoldOffCycles;
        out_ready <= 1'b0;
      end else begin
        if (stall_left == 0) begin
          ready_now = !ready_now;
          if (ready_now) begin
            stall_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 24);
          end else begin
            stall_left = $urandom_range(1, 6);
          end
        end
        stall_left--;
        out_ready <= ready_now;
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("sorted_table_binary_search_core_test: done, errors");
    $finish;
  end

  initial begin
    int r;
    int phase;
    int span;
    int searches;
    int step_max;
    int v;
    int k;
    int i;
    logic [CountW-1:0] cnt;
    bit refill;
    bit scrambled;
    logic signed [ValueW-1:0] t;

    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_cmd <= CMD_WRITE;
    in_entry_index <= '0;
    in_value <= '0;
    cfg_valid <= 1'b0;
    cfg_data <= '0;
    for (i = 0; i < TableDepth; i++) entry_model[i] = '0;
    entry_count_model = 1;
    burst_left = 0;
    items_sent = 0;

    directed_rows.push_back(write_row(0, 0));
    directed_rows.push_back(known_row(-32768, 0, OC_LOW));
    directed_rows.push_back(known_row(32767, 0, OC_HIGH));
    directed_rows.push_back(known_row(0, 0, OC_LOW));
    directed_rows.push_back(write_row(255, 32767));
    directed_rows.push_back(count_row(4));
    directed_rows.push_back(write_row(0, -100));
    directed_rows.push_back(write_row(1, -10));
    directed_rows.push_back(write_row(2, 10));
    directed_rows.push_back(write_row(3, 100));
    directed_rows.push_back(search_row(-10));
    directed_rows.push_back(search_row(10));
    directed_rows.push_back(search_row(0));
    directed_rows.push_back(search_row(55));
    directed_rows.push_back(known_row(-100, 0, OC_LOW));
    directed_rows.push_back(known_row(100, 3, OC_HIGH));
    directed_rows.push_back(known_row(32767, 3, OC_HIGH));
    directed_rows.push_back(known_row(-32768, 0, OC_LOW));
    directed_rows.push_back(count_row(0));
    directed_rows.push_back(known_row(50, 0, OC_HIGH));
    directed_rows.push_back(write_row(1, 500));
    directed_rows.push_back(count_row(3));
    directed_rows.push_back(search_row(5));
    directed_rows.push_back(known_row(500, 2, OC_HIGH));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    for (r = 0; r < directed_rows.size(); r++) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        set_entry_count(directed_rows[r].count);
      end else begin
        offer(directed_rows[r].cmd, directed_rows[r].idx, directed_rows[r].value,
              directed_rows[r].typed, directed_rows[r].answer);
      end
    end

    phase = 0;
    while (items_sent < ItemTarget) begin
      refill = 1'b1;
      case (phase)
        0: cnt = 2;
        1: cnt = 16;
        2: cnt = 0;
        3: cnt = 511;
        4: begin
          cnt = 256;
          refill = 1'b0;
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            cnt = CountW'($urandom_range(257, 511));
            refill = 1'b0;
          end else begin
            cnt = CountW'($urandom_range(0, 24));
          end
        end
      endcase
      set_entry_count(cnt);
      span = counted_entries();

      if (refill) begin
        if ($urandom_range(0, 2) == 0) begin
          step_max = $urandom_range(1, 8);
          v = int'($urandom_range(0, 60000)) - 32768;
        end else begin
          step_max = 65535 / span;
          v = int'($urandom_range(0, step_max)) - 32768;
        end
        scrambled = ($urandom_range(0, 7) == 0);
        for (i = 0; i < span; i++) begin
          offer(CMD_WRITE, IndexW'(i), scrambled ? ValueW'($urandom) : ValueW'(v), 1'b0, '0);
          v = v + int'($urandom_range(0, step_max));
          if (v > 32767) v = 32767;
        end
      end

      searches = (phase == 3) ? 24 : $urandom_range(6, 16);
      repeat (searches) begin
        if ($urandom_range(0, 15) == 0) begin
          offer(CMD_WRITE, IndexW'($urandom_range(0, span - 1)), ValueW'($urandom), 1'b0, '0);
        end
        k = $urandom_range(0, span - 1);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: t = entry_model[k];
          4, 5: t = ValueW'(int'(entry_model[k]) + (($urandom_range(0, 1) == 0) ? 1 : -1));
          6, 7: t = ValueW'($urandom);
          8: t = ($urandom_range(0, 1) == 0) ? 16'sh7fff : 16'sh8000;
          default: t = ($urandom_range(0, 1) == 0) ? entry_model[0] : entry_model[span-1];
        endcase
        offer(CMD_SEARCH, IndexW'($urandom), t, 1'b0, '0);
      end
      phase++;
    end

    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0) begin
      $display("sorted_table_binary_search_core_test: done, clean");
    end else begin
      $display("sorted_table_binary_search_core_test: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/stbs_pkg.sv
hw/rtl/stbs_ram.sv
hw/rtl/stbs_engine.sv
hw/rtl/sorted_table_binary_search_core.sv
dv/sorted_table_binary_search_core_test.sv
